FILE: hw/rtl/dihedral_pkg.sv
// Package with shared types, constants and a helper function for the dihedral angle block.
package dihedral_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int ANGLE_WIDTH  = 16;
  localparam int CORDIC_STEPS = 16;

  // Difference vectors before normalization need one extra bit.
  localparam int DIFF_WIDTH = COORD_WIDTH + 1;
  // Normalized vector components have magnitude at most 2^13.
  localparam int VEC_WIDTH  = 15;
  // The square root result is below 2^19.
  localparam int SQRT_STEPS = 19;
  localparam int SQRT_WIDTH = 20;
  // Jointly normalized x and y have magnitude below 2^30.
  localparam int XY_WIDTH   = 32;
  // CORDIC working width leaves headroom for the gain of about 1.65.
  localparam int CW_WIDTH   = 34;
  localparam int ATAN_ENTRIES = 24;

  localparam logic [63:0] VEC_LIM = 64'd8192;
  localparam logic [63:0] VEC_LOW = 64'd4096;
  localparam logic [63:0] XY_LIM  = 64'd1073741824;
  localparam logic [63:0] XY_LOW  = 64'd536870912;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] a_z;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] b_z;
    logic signed [COORD_WIDTH-1:0] c_x;
    logic signed [COORD_WIDTH-1:0] c_y;
    logic signed [COORD_WIDTH-1:0] c_z;
    logic signed [COORD_WIDTH-1:0] d_x;
    logic signed [COORD_WIDTH-1:0] d_y;
    logic signed [COORD_WIDTH-1:0] d_z;
  } in_req_t;

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] torsion;
    logic                          degenerate;
  } out_res_t;

  typedef logic signed [VEC_WIDTH-1:0] vcomp_t;
  typedef vcomp_t [2:0] vec_t;

  typedef logic signed [DIFF_WIDTH-1:0] dcomp_t;
  typedef dcomp_t [2:0] dvec_t;

  // Truncated arctangent table, pi equals 2^31.
  function automatic logic signed [31:0] atan_val(input int i);
    logic signed [31:0] t;
    case (i)
      0:  t = 32'h20000000;
      1:  t = 32'h12E4051D;
      2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4;
      4:  t = 32'h028B0D43;
      5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;
      7:  t = 32'h00517C55;
      8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2E;
      10: t = 32'h000A2F98;
      11: t = 32'h000517CC;
      12: t = 32'h00028BE6;
      13: t = 32'h000145F3;
      14: t = 32'h0000A2F9;
      15: t = 32'h0000517C;
      16: t = 32'h000028BE;
      17: t = 32'h0000145F;
      18: t = 32'h00000A2F;
      19: t = 32'h00000517;
      20: t = 32'h0000028B;
      21: t = 32'h00000145;
      22: t = 32'h000000A2;
      23: t = 32'h00000051;
      default: t = 32'sd0;
    endcase
    return t;
  endfunction

endpackage

FILE: hw/rtl/dihedral_vnorm.sv
// Power-of-two normalization of one difference vector, two register stages.
module dihedral_vnorm (
  input  logic                 clk,
  input  logic                 en,
  input  dihedral_pkg::dvec_t  vin,
  output dihedral_pkg::vec_t   vout
);

  localparam int DW = dihedral_pkg::DIFF_WIDTH;
  localparam int VW = dihedral_pkg::VEC_WIDTH;

  dihedral_pkg::dvec_t v_r;
  logic [4:0]          sh_r;
  logic                up_r;
  dihedral_pkg::vec_t  vout_r;

  logic [DW-1:0] m0, m1, m2, mx;
  logic [4:0]    sh_nxt;
  logic          up_nxt;

  // Stage one finds the largest magnitude and the shift amount.
  always_comb begin
    m0 = vin[0][DW-1] ? (~vin[0] + 1'b1) : vin[0];
    m1 = vin[1][DW-1] ? (~vin[1] + 1'b1) : vin[1];
    m2 = vin[2][DW-1] ? (~vin[2] + 1'b1) : vin[2];
    mx = m0;
    if (m1 > mx) mx = m1;
    if (m2 > mx) mx = m2;
    sh_nxt = '0;
    up_nxt = 1'b0;
    if ({39'd0, mx} >= dihedral_pkg::VEC_LIM) begin
      for (int k = 1; k < DW; k++) begin
        if (({39'd0, mx} >> k) >= dihedral_pkg::VEC_LIM) sh_nxt = 5'(k + 1);
      end
      if (sh_nxt == '0) sh_nxt = 5'd1;
    end else if (mx != '0) begin
      up_nxt = 1'b1;
      for (int k = 12; k >= 0; k--) begin
        if (({39'd0, mx} << k) >= dihedral_pkg::VEC_LOW) sh_nxt = 5'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r  <= vin;
      sh_r <= sh_nxt;
      up_r <= up_nxt;
    end
  end

  // Stage two applies the shift.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (up_r) vout_r[i] <= VW'(v_r[i] <<< sh_r);
        else      vout_r[i] <= VW'(v_r[i] >>> sh_r);
      end
    end
  end

  assign vout = vout_r;

endmodule

FILE: hw/rtl/dihedral_angle_four_points.sv
// Top level of the dihedral angle block: vector products, square root, CORDIC.
// Each accepted request raises its out_valid strobe when its result leaves the
// rounding stage, at the end of the pipeline below. Throughput is one request
// per cycle; busy is tied low since the receiver cannot stall and nothing else does.
// Stages: difference (1), normalization (2), products (2), square root (19, the first
// step beside the third product stage), y multiply (1), joint scaling and quadrant
// turn (2), CORDIC (16) and rounding (1). Reset, synchronous and active low, clears
// the valid bits only; payload registers hold whatever they held.
module dihedral_angle_four_points (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  dihedral_pkg::in_req_t  in_req,
  output logic                   out_valid,
  output dihedral_pkg::out_res_t out_res
);

  localparam int CW  = dihedral_pkg::CW_WIDTH;
  localparam int NS  = dihedral_pkg::CORDIC_STEPS;
  localparam int AW  = dihedral_pkg::ANGLE_WIDTH;
  localparam int SQN = dihedral_pkg::SQRT_STEPS;
  // Stage counts: diff 1, norm 2, products P0 and P1 2, then SQN root steps with
  // P2 beside the first one, y multiply 1, joint scaling 2, CORDIC NS, rounding 1.
  localparam int LAT = 1 + 2 + 2 + SQN + 1 + 2 + NS + 1;

  logic       go;
  logic [LAT-1:0] vld_r;

  // The pipeline never stalls, so every request is taken at once.
  assign busy = 1'b0;
  assign go   = start;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LAT-2:0], go};
  end

  // Stage D: difference vectors. The subtraction is exact in one extra bit.
  dihedral_pkg::dvec_t b1_r, b2_r, b3_r;
  always_ff @(posedge clk) begin
    b1_r[0] <= {in_req.a_x[23], in_req.a_x} - {in_req.b_x[23], in_req.b_x};
    b1_r[1] <= {in_req.a_y[23], in_req.a_y} - {in_req.b_y[23], in_req.b_y};
    b1_r[2] <= {in_req.a_z[23], in_req.a_z} - {in_req.b_z[23], in_req.b_z};
    b2_r[0] <= {in_req.b_x[23], in_req.b_x} - {in_req.c_x[23], in_req.c_x};
    b2_r[1] <= {in_req.b_y[23], in_req.b_y} - {in_req.c_y[23], in_req.c_y};
    b2_r[2] <= {in_req.b_z[23], in_req.b_z} - {in_req.c_z[23], in_req.c_z};
    b3_r[0] <= {in_req.c_x[23], in_req.c_x} - {in_req.d_x[23], in_req.d_x};
    b3_r[1] <= {in_req.c_y[23], in_req.c_y} - {in_req.d_y[23], in_req.d_y};
    b3_r[2] <= {in_req.c_z[23], in_req.c_z} - {in_req.d_z[23], in_req.d_z};
  end

  // Each vector is scaled by its own power of two; the angle is unaffected.
  dihedral_pkg::vec_t n1, n2, n3;
  dihedral_vnorm u_n1 (.clk(clk), .en(1'b1), .vin(b1_r), .vout(n1));
  dihedral_vnorm u_n2 (.clk(clk), .en(1'b1), .vin(b2_r), .vout(n2));
  dihedral_vnorm u_n3 (.clk(clk), .en(1'b1), .vin(b3_r), .vout(n3));

  // Products stage one: the two cross products and the squares of b2.
  logic signed [31:0] c12_r [3];
  logic signed [31:0] c23_r [3];
  logic signed [29:0] sq_r [3];
  dihedral_pkg::vec_t p1_r;
  always_ff @(posedge clk) begin
    c12_r[0] <= 32'(n1[1] * n2[2]) - 32'(n1[2] * n2[1]);
    c12_r[1] <= 32'(n1[2] * n2[0]) - 32'(n1[0] * n2[2]);
    c12_r[2] <= 32'(n1[0] * n2[1]) - 32'(n1[1] * n2[0]);
    c23_r[0] <= 32'(n2[1] * n3[2]) - 32'(n2[2] * n3[1]);
    c23_r[1] <= 32'(n2[2] * n3[0]) - 32'(n2[0] * n3[2]);
    c23_r[2] <= 32'(n2[0] * n3[1]) - 32'(n2[1] * n3[0]);
    for (int i = 0; i < 3; i++) sq_r[i] <= 30'(n2[i] * n2[i]);
    p1_r <= n1;
  end

  // Products stage two: the triple product term-wise, the dot of the crosses
  // term-wise, and the sum of squares for the square root.
  logic signed [47:0] tp_r [3];
  logic signed [63:0] dd_r [3];
  logic [39:0]        n2sq_r;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      tp_r[i] <= 48'(p1_r[i] * c23_r[i]);
      dd_r[i] <= 64'(c12_r[i] * c23_r[i]);
    end
    n2sq_r <= 40'({10'd0, sq_r[0]} + {10'd0, sq_r[1]} + {10'd0, sq_r[2]}) << 8;
  end

  // Products stage three: sums. Results then wait in a delay line for the root.
  logic signed [47:0] trip_r;
  logic signed [63:0] xd_r;
  always_ff @(posedge clk) begin
    trip_r <= tp_r[0] + tp_r[1] + tp_r[2];
    xd_r   <= (dd_r[0] + dd_r[1] + dd_r[2]) <<< 4;
  end

  // Bit-serial square root, one step a stage. Step 0 starts with n2sq_r,
  // so the root is ready in the last step register, sq_res_r[SQN-1].
  logic [39:0] sq_n_r   [SQN];
  logic [39:0] sq_res_r [SQN];
  always_ff @(posedge clk) begin
    for (int s = 0; s < SQN; s++) begin
      logic [39:0] n_in, r_in, bitv;
      n_in = (s == 0) ? n2sq_r : sq_n_r[s-1];
      r_in = (s == 0) ? '0     : sq_res_r[s-1];
      bitv = 40'd1 << (2 * (SQN - 1 - s));
      if (n_in >= r_in + bitv) begin
        sq_n_r[s]   <= n_in - (r_in + bitv);
        sq_res_r[s] <= (r_in >> 1) + bitv;
      end else begin
        sq_n_r[s]   <= n_in;
        sq_res_r[s] <= r_in >> 1;
      end
    end
  end

  // Delay line for the triple product and x so they meet the root.
  localparam int DLY = SQN - 1;
  logic signed [47:0] trip_d_r [DLY];
  logic signed [63:0] xd_d_r   [DLY];
  always_ff @(posedge clk) begin
    trip_d_r[0] <= trip_r;
    xd_d_r[0]   <= xd_r;
    for (int s = 1; s < DLY; s++) begin
      trip_d_r[s] <= trip_d_r[s-1];
      xd_d_r[s]   <= xd_d_r[s-1];
    end
  end

  // y = root times triple product; magnitudes fit 20 + 44 bits.
  logic signed [63:0] ym_r, xm_r;
  always_ff @(posedge clk) begin
    ym_r <= 64'($signed({1'b0, sq_res_r[SQN-1][19:0]}) * trip_d_r[DLY-1]);
    xm_r <= xd_d_r[DLY-1];
  end

  // Joint scaling, stage one: shift amount from the larger magnitude.
  logic [63:0] ax, ay, amx;
  logic [5:0]  jsh_nxt;
  logic        jup_nxt;
  logic [5:0]  jsh_r;
  logic        jup_r;
  logic signed [63:0] ys_r, xs_r;
  always_comb begin
    ax  = xm_r[63] ? (~xm_r + 1'b1) : xm_r;
    ay  = ym_r[63] ? (~ym_r + 1'b1) : ym_r;
    amx = (ax > ay) ? ax : ay;
    jsh_nxt = '0;
    jup_nxt = 1'b0;
    if (amx >= dihedral_pkg::XY_LIM) begin
      for (int k = 1; k < 40; k++) begin
        if ((amx >> k) >= dihedral_pkg::XY_LIM) jsh_nxt = 6'(k + 1);
      end
      if (jsh_nxt == '0) jsh_nxt = 6'd1;
    end else if (amx != '0) begin
      jup_nxt = 1'b1;
      for (int k = 29; k >= 0; k--) begin
        if ((amx << k) >= dihedral_pkg::XY_LOW) jsh_nxt = 6'(k);
      end
    end
  end
  always_ff @(posedge clk) begin
    jsh_r <= jsh_nxt;
    jup_r <= jup_nxt;
    ys_r  <= ym_r;
    xs_r  <= xm_r;
  end

  // Joint scaling, stage two, and the quadrant turn into the right half plane.
  logic signed [CW-1:0] xn, yn;
  logic signed [31:0]   zi;
  logic signed [CW-1:0] cx_r [NS+1];
  logic signed [CW-1:0] cy_r [NS+1];
  logic signed [31:0]   cz_r [NS+1];
  logic                 deg_r [NS+1];
  logic                 axis_r [NS+1];
  logic                 neg_r [NS+1];
  always_comb begin
    if (jup_r) begin
      xn = CW'(xs_r <<< jsh_r);
      yn = CW'(ys_r <<< jsh_r);
    end else begin
      xn = CW'(xs_r >>> jsh_r);
      yn = CW'(ys_r >>> jsh_r);
    end
    zi = '0;
  end
  always_ff @(posedge clk) begin
    deg_r[0]  <= (xn == '0) && (yn == '0);
    axis_r[0] <= (yn == '0);
    neg_r[0]  <= xn[CW-1];
    if (xn[CW-1]) begin
      if (!yn[CW-1]) begin
        cx_r[0] <= yn;
        cy_r[0] <= -xn;
        cz_r[0] <= 32'sh40000000;
      end else begin
        cx_r[0] <= -yn;
        cy_r[0] <= xn;
        cz_r[0] <= -32'sh40000000;
      end
    end else begin
      cx_r[0] <= xn;
      cy_r[0] <= yn;
      cz_r[0] <= zi;
    end
  end

  // CORDIC vectoring, one step a stage.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (!cy_r[i][CW-1]) begin
        cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] + dihedral_pkg::atan_val(i);
      end else begin
        cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] - dihedral_pkg::atan_val(i);
      end
      deg_r[i+1]  <= deg_r[i];
      axis_r[i+1] <= axis_r[i];
      neg_r[i+1]  <= neg_r[i];
    end
  end

  // Rounding to the output angle, with the exact cases on the axis.
  logic signed [32:0] zr;
  dihedral_pkg::out_res_t res_r;
  always_comb begin
    zr = {cz_r[NS][31], cz_r[NS]} + 33'(64'sd1 <<< (31 - AW));
  end
  always_ff @(posedge clk) begin
    res_r.degenerate <= deg_r[NS];
    if (deg_r[NS]) begin
      res_r.torsion <= '0;
    end else if (axis_r[NS]) begin
      res_r.torsion <= neg_r[NS] ? {1'b1, {(AW-1){1'b0}}} : '0;
    end else begin
      res_r.torsion <= zr[32-AW +: AW];
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_res   = res_r;

`ifndef SYNTH
  // The result strobe follows a request by exactly the pipeline latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] |-> ##(LAT-1) out_valid)) else $error("result strobe lost");
  // A degenerate result always carries angle zero.
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.degenerate) |-> (out_res.torsion == '0))
    else $error("degenerate result with nonzero angle");
  // No result appears without a request that caused it.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld_r[LAT-2])) else $error("spurious result");
`endif

endmodule
